// ===== sv/dffr_pkg.sv =====
// ---------------------------------------------------------------------------
// dffr_pkg
// Types, codes and the send-twice classifier for the forward frame receiver.
// ---------------------------------------------------------------------------
package dffr_pkg;

  localparam int unsigned FrameBits   = 16;
  localparam int unsigned CountBits   = 8;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgDataBits-1:0] ThresholdReset = 16'd650;
  localparam logic [CountBits-1:0]   FrameLen       = 8'd16;
  localparam logic [CountBits-1:0]   ShortLen       = 8'd8;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegLoopback  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegThreshold = 1'b1;

  typedef enum logic [1:0] {
    CMD_EDGE    = 2'd0,
    CMD_END     = 2'd1,
    CMD_EXPIRE  = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_HELD    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [15:0]          edge_duration;
    logic                 line_level;
    logic                 tx_active;
  } evt_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [FrameBits-1:0] frame_word;
  } res_t;

  // send-twice commands: special addresses, or commands 0x20..0x81 sent
  // to a command-form (odd) address outside the plain range 0x82..0xFD
  function automatic logic needs_repeat(input logic [FrameBits-1:0] frame);
    logic [7:0] addr;
    logic [7:0] data;
    logic       rep;
    addr = frame[15:8];
    data = frame[7:0];
    rep  = 1'b0;
    if (addr == 8'hA5 || addr == 8'hA7) begin
      rep = 1'b1;
    end else if (data >= 8'h20 && data <= 8'h81 && addr[0] &&
                 !(addr >= 8'h82 && addr <= 8'hFD)) begin
      rep = 1'b1;
    end
    return rep;
  endfunction

endpackage

// ===== sv/dffr_decoder.sv =====
// ---------------------------------------------------------------------------
// dffr_decoder
// Manchester decode state, send-twice filter and configuration registers.
// ---------------------------------------------------------------------------
module dffr_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dffr_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [dffr_pkg::CfgDataBits-1:0]    cfg_data,
  input  logic                                accept,
  input  dffr_pkg::evt_t                      evt,
  output dffr_pkg::res_t                      res
);

  logic                               loopback_enable;
  logic [15:0]                        half_bit_threshold;

  logic                               receiving, receiving_next;
  logic [dffr_pkg::CountBits-1:0]     bit_count, bit_count_next;
  logic [dffr_pkg::FrameBits-1:0]     shift_word, shift_word_next;
  logic                               half_parity, half_parity_next;
  logic                               window_open, window_open_next;
  logic [dffr_pkg::FrameBits-1:0]     held_frame, held_frame_next;

  logic                               parity_step;
  logic [dffr_pkg::CountBits-1:0]     bits;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      loopback_enable    <= 1'b1;
      half_bit_threshold <= dffr_pkg::ThresholdReset;
    end else if (cfg_we) begin
      case (cfg_index)
        dffr_pkg::RegLoopback:  loopback_enable    <= cfg_data[0];
        dffr_pkg::RegThreshold: half_bit_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign parity_step = half_parity ^ (evt.edge_duration < half_bit_threshold);
  assign bits        = bit_count - 8'd1;

  always_comb begin
    receiving_next   = receiving;
    bit_count_next   = bit_count;
    shift_word_next  = shift_word;
    half_parity_next = half_parity;
    window_open_next = window_open;
    held_frame_next  = held_frame;
    res.result_kind  = dffr_pkg::KIND_NONE;
    res.frame_word   = '0;
    case (evt.cmd)
      dffr_pkg::CMD_EDGE: begin
        if (loopback_enable || !evt.tx_active) begin
          if (!receiving) begin
            if (!evt.line_level) begin
              receiving_next   = 1'b1;
              bit_count_next   = '0;
              shift_word_next  = '0;
              half_parity_next = 1'b1;
            end
          end else begin
            half_parity_next = parity_step;
            if (!parity_step) begin
              if (bit_count != '0) begin
                shift_word_next = {shift_word[dffr_pkg::FrameBits-2:0], evt.line_level};
              end
              bit_count_next = bit_count + 8'd1;
            end
          end
        end
      end
      dffr_pkg::CMD_END: begin
        if (receiving) begin
          if (bits == dffr_pkg::FrameLen) begin
            res.frame_word = shift_word;
            if (!dffr_pkg::needs_repeat(shift_word)) begin
              res.result_kind = dffr_pkg::KIND_DELIVER;
            end else if (window_open && shift_word == held_frame) begin
              window_open_next = 1'b0;
              held_frame_next  = '0;
              res.result_kind  = dffr_pkg::KIND_DELIVER;
            end else begin
              held_frame_next  = shift_word;
              window_open_next = 1'b1;
              res.result_kind  = dffr_pkg::KIND_HELD;
            end
          end else if (bits != dffr_pkg::ShortLen) begin
            res.result_kind = dffr_pkg::KIND_ERROR;
          end
        end
        receiving_next   = 1'b0;
        bit_count_next   = '0;
        shift_word_next  = '0;
        half_parity_next = 1'b0;
      end
      dffr_pkg::CMD_EXPIRE: begin
        held_frame_next  = '0;
        window_open_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      bit_count   <= '0;
      shift_word  <= '0;
      half_parity <= 1'b0;
      window_open <= 1'b0;
      held_frame  <= '0;
    end else if (accept) begin
      receiving   <= receiving_next;
      bit_count   <= bit_count_next;
      shift_word  <= shift_word_next;
      half_parity <= half_parity_next;
      window_open <= window_open_next;
      held_frame  <= held_frame_next;
    end
  end

endmodule

// ===== sv/dffr_skid.sv =====
// ---------------------------------------------------------------------------
// dffr_skid
// Result register with a spare slot; upstream stall comes from a flop.
// ---------------------------------------------------------------------------
module dffr_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dffr_pkg::res_t  push_data,
  output logic            full,
  output logic            res_valid,
  input  logic            res_stall,
  output dffr_pkg::res_t  res_request
);

  logic           spare_valid;
  dffr_pkg::res_t spare_data;

  assign full = spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (spare_valid) begin
        res_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (spare_valid) begin
        res_request <= spare_data;
      end else if (push) begin
        res_request <= push_data;
      end
    end else if (push && !spare_valid) begin
      spare_data <= push_data;
    end
  end

endmodule

// ===== sv/dali_forward_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// dali_forward_frame_receiver
// Manchester decoder for DALI forward frames, fed by timed edge events.
// ---------------------------------------------------------------------------
// One event request is taken per clock while evt_stall is low; every event
// yields exactly one result request, registered, via the spare slot if stalled.
// The decode state updates in the acceptance cycle, so back-to-back events
// see each other's effect with no gap. The result side is a register plus a
// spare slot: evt_stall rises only once a result has been held back and the
// spare is occupied, and it comes straight from a flop. Throughput is one
// event per cycle while results are drained. Configuration (loopback enable
// at index 0, half-bit threshold at index 1) is written via cfg_we and takes
// effect from the next event.
module dali_forward_frame_receiver (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [dffr_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [dffr_pkg::CfgDataBits-1:0]  cfg_data,
  // edge events
  input  logic                              evt_valid,
  output logic                              evt_stall,
  input  dffr_pkg::evt_t                    evt_request,
  // results
  output logic                              res_valid,
  input  logic                              res_stall,
  output dffr_pkg::res_t                    res_request
);

  logic           accept;
  dffr_pkg::res_t result;

  // accepted when valid and the spare slot is free
  assign accept = evt_valid && !evt_stall;

  dffr_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .evt       (evt_request),
    .res       (result)
  );

  dffr_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_data   (result),
    .full        (evt_stall),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_request (res_request)
  );

endmodule

// ===== sv/dffr_checker.sv =====
// ---------------------------------------------------------------------------
// dffr_checker
// Port-level checks for the forward frame receiver.
// ---------------------------------------------------------------------------
module dffr_checker (
  input logic            clk,
  input logic            rst,
  input logic            evt_stall,
  input logic            res_valid,
  input logic            res_stall,
  input dffr_pkg::res_t  res_request
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a held-back result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_request))
    else $error("stalled result changed");

  // only frames carry a word
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_request.result_kind == dffr_pkg::KIND_NONE ||
                  res_request.result_kind == dffr_pkg::KIND_ERROR)
    |-> res_request.frame_word == '0)
    else $error("word on empty or error result");

  // only send-twice commands are held
  a_held_repeat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_request.result_kind == dffr_pkg::KIND_HELD
    |-> dffr_pkg::needs_repeat(res_request.frame_word))
    else $error("held frame is not a send-twice command");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    evt_stall |-> $past(res_valid && res_stall))
    else $error("event stall without result stall");

endmodule

bind dali_forward_frame_receiver dffr_checker u_dffr_checker (
  .clk         (clk),
  .rst         (rst),
  .evt_stall   (evt_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .res_request (res_request)
);

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the DALI forward frame receiver. Manchester edge
// streams, framing faults, send-twice filtering and both configuration
// registers are driven under random valid/stall pressure. Every result
// request is compared with an in-bench decoder.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 90;
  localparam int unsigned EvtBits     = $bits(dffr_pkg::evt_t);

  // send-twice address/command classes
  localparam logic [7:0] SpecialAddrLo = 8'hA5;
  localparam logic [7:0] SpecialAddrHi = 8'hA7;
  localparam logic [7:0] RepeatCmdMin  = 8'h20;
  localparam logic [7:0] RepeatCmdMax  = 8'h81;
  localparam logic [7:0] PlainAddrMin  = 8'h82;
  localparam logic [7:0] PlainAddrMax  = 8'hFD;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [dffr_pkg::CfgIdxBits-1:0]  cfg_index = '0;
  logic [dffr_pkg::CfgDataBits-1:0] cfg_data = '0;
  logic                             evt_valid = 1'b0;
  logic                             evt_stall;
  dffr_pkg::evt_t                   evt_request = '0;
  logic                             res_valid;
  logic                             res_stall = 1'b0;
  dffr_pkg::res_t                   res_request;

  // bench copy of configuration and decode state
  bit          cfg_loopback = 1'b1;
  logic [15:0] cfg_threshold = dffr_pkg::ThresholdReset;
  bit          rx_busy = 1'b0;
  logic [7:0]  rx_bits = '0;
  logic [15:0] rx_word = '0;
  bit          rx_phase = 1'b0;
  bit          rpt_open = 1'b0;
  logic [15:0] rpt_frame = '0;

  int unsigned    send_idle_pct = 35;
  int unsigned    recv_idle_pct = 52;
  int unsigned    n_sent = 0;
  int             n_fail = 0;
  dffr_pkg::res_t frames_due[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dali_forward_frame_receiver u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt_request(evt_request),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_request(res_request)
  );

  function automatic bit wants_repeat(input logic [15:0] frame);
    logic [7:0] a;
    logic [7:0] d;
    a = frame[15:8];
    d = frame[7:0];
    if (a == SpecialAddrLo || a == SpecialAddrHi) return 1'b1;
    return a[0] && (a < PlainAddrMin || a > PlainAddrMax) &&
           d >= RepeatCmdMin && d <= RepeatCmdMax;
  endfunction

  // advances the bench decoder by one event and returns the result it owes
  function automatic dffr_pkg::res_t decode_event(input dffr_pkg::evt_t e);
    dffr_pkg::res_t r;
    logic [7:0]     len;
    r = '0;
    case (e.cmd)
      dffr_pkg::CMD_EDGE: begin
        if (cfg_loopback || !e.tx_active) begin
          if (!rx_busy) begin
            if (!e.line_level) begin
              rx_busy  = 1'b1;
              rx_bits  = '0;
              rx_word  = '0;
              rx_phase = 1'b1;
            end
          end else begin
            if (e.edge_duration < cfg_threshold) rx_phase = ~rx_phase;
            if (!rx_phase) begin
              // start bit is counted but not stored
              if (rx_bits != 0) rx_word = {rx_word[14:0], e.line_level};
              rx_bits = rx_bits + 8'd1;
            end
          end
        end
      end
      dffr_pkg::CMD_END: begin
        if (rx_busy) begin
          len = rx_bits - 8'd1;
          if (len == dffr_pkg::FrameLen) begin
            r.frame_word = rx_word;
            if (!wants_repeat(rx_word)) begin
              r.result_kind = dffr_pkg::KIND_DELIVER;
            end else if (rpt_open && rx_word == rpt_frame) begin
              rpt_open      = 1'b0;
              rpt_frame     = '0;
              r.result_kind = dffr_pkg::KIND_DELIVER;
            end else begin
              rpt_frame     = rx_word;
              rpt_open      = 1'b1;
              r.result_kind = dffr_pkg::KIND_HELD;
            end
          end else if (len != dffr_pkg::ShortLen) begin
            r.result_kind = dffr_pkg::KIND_ERROR;
          end
        end
        rx_busy  = 1'b0;
        rx_bits  = '0;
        rx_word  = '0;
        rx_phase = 1'b0;
      end
      dffr_pkg::CMD_EXPIRE: begin
        rpt_open  = 1'b0;
        rpt_frame = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(negedge clk) begin
    res_stall <= $urandom_range(0, 99) < recv_idle_pct;
  end

  always @(posedge clk) begin
    dffr_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (frames_due.size() == 0) begin
        n_fail++;
        $error("result request with none due: kind %0d word %h",
               res_request.result_kind, res_request.frame_word);
      end else begin
        want = frames_due.pop_front();
        if (res_request.result_kind !== want.result_kind) begin
          n_fail++;
          $error("result_kind: expected %0d, got %0d", want.result_kind,
                 res_request.result_kind);
        end
        if (res_request.frame_word !== want.frame_word) begin
          n_fail++;
          $error("frame_word: expected %h, got %h", want.frame_word,
                 res_request.frame_word);
        end
      end
    end
  end

  task automatic send_event(input dffr_pkg::evt_t e);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt_valid <= 1'b0;
      @(negedge clk);
    end
    evt_valid   <= 1'b1;
    evt_request <= e;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    frames_due.push_back(decode_event(e));
    n_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    evt_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dffr_pkg::CfgIdxBits-1:0] idx,
                           input logic [15:0] val);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dffr_pkg::RegLoopback) cfg_loopback = val[0];
    else cfg_threshold = val;
  endtask

  function automatic logic [15:0] short_span();
    int unsigned t;
    t = cfg_threshold;
    if (t == 0) return '0;
    if ($urandom_range(0, 4) != 0) return 16'($urandom_range(t / 2, t - 1));
    return 16'($urandom_range(0, t - 1));
  endfunction

  function automatic logic [15:0] long_span();
    int unsigned t;
    int unsigned hi;
    t  = cfg_threshold;
    hi = (2 * t > 65535) ? 65535 : 2 * t;
    if ($urandom_range(0, 99) < 15) return 16'($urandom_range(t, 65535));
    return 16'($urandom_range(t, hi));
  endfunction

  // tx_active mostly quiet when loopback is off, so frames mostly survive
  function automatic dffr_pkg::evt_t make_edge(input logic [15:0] dur,
                                               input logic level);
    dffr_pkg::evt_t e;
    e.cmd           = dffr_pkg::CMD_EDGE;
    e.edge_duration = dur;
    e.line_level    = level;
    e.tx_active     = cfg_loopback ? 1'($urandom) : ($urandom_range(0, 19) == 0);
    return e;
  endfunction

  function automatic dffr_pkg::evt_t misc_event(input logic [1:0] c);
    dffr_pkg::evt_t e;
    e               = dffr_pkg::evt_t'(EvtBits'($urandom));
    e.cmd           = c;
    return e;
  endfunction

  // start bit plus data bits as Manchester half bits, one event per edge
  task automatic send_bits(input bit data[$]);
    bit halves[$];
    int run;
    halves = {1'b0, 1'b1};
    foreach (data[i]) begin
      halves.push_back(~data[i]);
      halves.push_back(data[i]);
    end
    send_event(make_edge(16'($urandom), 1'b0));
    run = 1;
    for (int i = 1; i < halves.size(); i++) begin
      if (halves[i] != halves[i-1]) begin
        send_event(make_edge(run == 1 ? short_span() : long_span(), halves[i]));
        run = 1;
      end else begin
        run++;
      end
    end
    // line returns high after a trailing zero
    if (!halves[halves.size()-1]) begin
      send_event(make_edge(run == 1 ? short_span() : long_span(), 1'b1));
    end
  endtask

  task automatic send_frame(input logic [15:0] word, input int nbits);
    bit data[$];
    for (int i = nbits - 1; i >= 0; i--) begin
      data.push_back(i < 16 ? word[i] : 1'($urandom));
    end
    send_bits(data);
    send_event(misc_event(dffr_pkg::CMD_END));
  endtask

  function automatic logic [15:0] twice_word();
    logic [7:0] a;
    logic [7:0] d;
    case ($urandom_range(0, 2))
      0:       a = SpecialAddrLo;
      1:       a = SpecialAddrHi;
      default: a = ($urandom_range(0, 3) == 0) ? 8'hFF : {7'($urandom_range(0, 64)), 1'b1};
    endcase
    d = (a == SpecialAddrLo || a == SpecialAddrHi) ? 8'($urandom)
                                                   : 8'($urandom_range(RepeatCmdMin,
                                                                        RepeatCmdMax));
    return {a, d};
  endfunction

  task automatic test_plain_frames();
    send_frame(16'h0102, 16);
    send_frame(16'hFFFF, 16);
    send_frame(16'h0000, 16);
  endtask

  task automatic test_idle_events();
    send_event(make_edge(16'h0000, 1'b1));   // rising edge while idle
    send_event(make_edge(16'hFFFF, 1'b1));
    send_event(misc_event(dffr_pkg::CMD_UNUSED));
    send_event(misc_event(dffr_pkg::CMD_END));         // end while idle
    send_event(misc_event(dffr_pkg::CMD_EXPIRE));
    send_event(make_edge(16'hFFFF, 1'b0));   // start, then end at once
    send_event(misc_event(dffr_pkg::CMD_END));
    send_frame(16'h00C3, 8);                 // short frame, dropped
    send_frame(16'h0ABC, 12);
    send_frame(16'h1234, 17);
  endtask

  task automatic test_send_twice();
    send_frame(16'hA512, 16);
    send_frame(16'hA512, 16);                // confirmed
    send_frame(16'hA700, 16);
    send_frame(16'hA7FF, 16);                // differs: replaces held frame
    send_frame(16'hA7FF, 16);
    send_frame(16'h0120, 16);
    send_event(misc_event(dffr_pkg::CMD_EXPIRE));
    send_frame(16'h0120, 16);                // window closed: held again
    send_frame(16'hFF81, 16);
    send_frame(16'hFF81, 16);
    send_frame(16'h8330, 16);                // plain range address
    send_frame(16'h811F, 16);
  endtask

  task automatic test_config_extremes();
    dffr_pkg::evt_t e;
    write_reg(dffr_pkg::RegLoopback, 16'hFFFE);
    e = make_edge(16'd500, 1'b0);
    e.tx_active = 1'b1;                      // own transmission, ignored
    send_event(e);
    send_frame(16'h3C5A, 16);
    e = make_edge(16'd400, 1'b1);
    e.tx_active = 1'b1;
    send_event(e);
    send_frame(16'h0280, 16);
    write_reg(dffr_pkg::RegThreshold, 16'h0000);
    send_frame(16'h5555, 16);
    write_reg(dffr_pkg::RegThreshold, 16'hFFFF);
    send_frame(16'hC0DE, 16);
    write_reg(dffr_pkg::RegThreshold, 16'h0001);
    send_frame(16'h9009, 16);
    write_reg(dffr_pkg::RegThreshold, dffr_pkg::ThresholdReset);
    write_reg(dffr_pkg::RegLoopback, 16'h0001);
  endtask

  // 273 completed bits wraps the count back to a full frame
  task automatic test_count_wrap();
    send_event(make_edge(16'($urandom), 1'b0));
    send_event(make_edge(short_span(), 1'b1));
    repeat (272) send_event(make_edge(long_span(), 1'($urandom)));
    send_event(misc_event(dffr_pkg::CMD_END));
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    logic [15:0] w;
    bit          data[$];
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0:       begin send_idle_pct = 35; recv_idle_pct = 52; end
        1:       begin send_idle_pct = 52; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_reg(dffr_pkg::RegLoopback, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
      pick = $urandom_range(0, 9);
      write_reg(dffr_pkg::RegThreshold,
                pick < 6 ? dffr_pkg::ThresholdReset :
                pick < 9 ? 16'($urandom_range(500, 800)) : 16'($urandom));
      target = n_sent + RandomItems / 3;
      while (n_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_frame(16'($urandom), 16);
        end else if (pick < 70) begin
          w = twice_word();
          send_frame(w, 16);
          if ($urandom_range(0, 4) == 0) send_event(misc_event(dffr_pkg::CMD_EXPIRE));
          if ($urandom_range(0, 4) == 0) w[$urandom_range(0, 15)] ^= 1'b1;
          send_frame(w, 16);
        end else if (pick < 85) begin
          if ($urandom_range(0, 1)) begin
            send_frame(16'($urandom), $urandom_range(0, 20));
          end else begin
            data.delete();
            repeat ($urandom_range(2, 16)) data.push_back(1'($urandom));
            send_bits(data);
            send_event(make_edge(16'($urandom), 1'($urandom)));  // stray edge
            send_event(misc_event(dffr_pkg::CMD_END));
          end
        end else begin
          send_event(misc_event(2'($urandom)));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_plain_frames();
    test_idle_events();
    test_send_twice();
    test_config_extremes();
    test_count_wrap();
    test_random_traffic();
    @(negedge clk);
    evt_valid <= 1'b0;
    for (int i = 0; i < 20000 && frames_due.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frames_due.size() != 0) begin
      n_fail++;
      $error("%0d result requests never arrived", frames_due.size());
    end
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
